// ===== rtl/dsfc_pkg.sv =====
package dsfc_pkg;

  // table geometry
  localparam int RECORDS = 64;
  localparam int AW      = (RECORDS > 1) ? $clog2(RECORDS) : 1;

  // field widths
  localparam int IDX_W  = 6;
  localparam int SIG_W  = 24;
  localparam int FUSE_W = 24;

  // stream widths
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 8;

  // erased signature, also the "no device" code
  localparam logic [SIG_W-1:0] SIG_ERASED = '1;

  // item kinds on the input tuser
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // one stored record: bytes low 23..16, ext 15..8, lock 7..0
  typedef struct packed {
    logic [SIG_W-1:0]  sig;
    logic [FUSE_W-1:0] fuse;
    logic [FUSE_W-1:0] mask;
  } rec_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic load;
    logic scan;
    logic push;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_query;
    logic no_dev;
    logic done;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/dsfc_ctrl.sv =====
module dsfc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  dsfc_pkg::sts_t  sts_i,
  output dsfc_pkg::cmd_t  cmd_o
);

  dsfc_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dsfc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      dsfc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (sts_i.is_query) begin
            cmd_o.start = 1'b1;
            state_d     = sts_i.no_dev ? dsfc_pkg::ST_WAIT : dsfc_pkg::ST_SCAN;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      dsfc_pkg::ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.done) begin
          state_d = dsfc_pkg::ST_WAIT;
        end
      end
      dsfc_pkg::ST_WAIT: begin
        if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = dsfc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dsfc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/dsfc_dp.sv =====
module dsfc_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [dsfc_pkg::IN_DATA_W-1:0]     in_data_i,
  input  logic                               in_user_i,
  input  dsfc_pkg::cmd_t                     cmd_i,
  output dsfc_pkg::sts_t                     sts_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [dsfc_pkg::OUT_DATA_W-1:0]    out_data_o
);

  // input fields
  logic [dsfc_pkg::IDX_W-1:0]  in_index;
  logic [dsfc_pkg::SIG_W-1:0]  in_sig;
  logic [dsfc_pkg::FUSE_W-1:0] in_fuse;
  logic [dsfc_pkg::FUSE_W-1:0] in_mask;
  dsfc_pkg::rec_t              wr_rec;
  logic                        wr_ok;
  logic [dsfc_pkg::AW-1:0]     wr_addr;

  assign in_index = in_data_i[5:0];
  assign in_sig   = in_data_i[29:6];
  assign in_fuse  = {in_data_i[37:30], in_data_i[45:38], in_data_i[53:46]};
  assign in_mask  = {in_data_i[61:54], in_data_i[69:62], in_data_i[77:70]};
  assign wr_rec   = '{sig: in_sig, fuse: in_fuse, mask: in_mask};
  assign wr_ok    = (32'(in_index) < dsfc_pkg::RECORDS);
  assign wr_addr  = dsfc_pkg::AW'(in_index);

  // record store and valid bits
  dsfc_pkg::rec_t                  mem_q [dsfc_pkg::RECORDS];
  logic [dsfc_pkg::RECORDS-1:0]    vld_q;
  dsfc_pkg::rec_t                  rd_q;
  logic                            rd_vld_q;

  // scan control
  logic [dsfc_pkg::AW-1:0]         addr_q;
  logic [dsfc_pkg::AW-1:0]         slot_q;
  logic                            last_q;
  logic                            pend_q;
  logic                            issue;

  // query operands and result
  logic [dsfc_pkg::SIG_W-1:0]      qsig_q;
  logic [dsfc_pkg::FUSE_W-1:0]     qfuse_q;
  logic [dsfc_pkg::OUT_DATA_W-1:0] res_q;
  logic [dsfc_pkg::OUT_DATA_W-1:0] res_d;

  // output register
  logic                            out_valid_q;
  logic [dsfc_pkg::OUT_DATA_W-1:0] out_data_q;

  logic [dsfc_pkg::SIG_W-1:0]      rd_sig;
  logic                            erased;
  logic                            match;
  logic                            fuse_bad;
  logic                            at_end;
  logic                            done;

  assign issue = cmd_i.scan && !last_q;

  // memory write on load, registered read during the scan
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && wr_ok) begin
      mem_q[wr_addr] <= wr_rec;
    end
    if (issue) begin
      rd_q     <= mem_q[addr_q];
      rd_vld_q <= vld_q[addr_q];
    end
  end

  // valid bits, an unwritten slot reads as erased
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (cmd_i.load && wr_ok) begin
      vld_q[wr_addr] <= 1'b1;
    end
  end

  // read address walk, one slot a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
      slot_q <= '0;
      last_q <= 1'b0;
      pend_q <= 1'b0;
    end else if (cmd_i.start) begin
      addr_q <= '0;
      last_q <= 1'b0;
      pend_q <= 1'b0;
    end else begin
      pend_q <= issue;
      if (issue) begin
        slot_q <= addr_q;
        addr_q <= addr_q + 1'b1;
        last_q <= (addr_q == dsfc_pkg::AW'(dsfc_pkg::RECORDS - 1));
      end
    end
  end

  // compare the slot read in the previous cycle
  assign rd_sig   = rd_vld_q ? rd_q.sig : dsfc_pkg::SIG_ERASED;
  assign erased   = (rd_sig == dsfc_pkg::SIG_ERASED);
  assign match    = (rd_sig == qsig_q);
  assign fuse_bad = |((qfuse_q ^ rd_q.fuse) & rd_q.mask);
  assign at_end   = (slot_q == dsfc_pkg::AW'(dsfc_pkg::RECORDS - 1));
  assign done     = pend_q && (erased || match || at_end);

  // result packing: red, green, hit slot
  always_comb begin
    if (match) begin
      res_d = {dsfc_pkg::IDX_W'(slot_q), 1'b1, fuse_bad};
    end else begin
      res_d = {{dsfc_pkg::IDX_W{1'b0}}, 1'b0, 1'b1};
    end
  end

  // query operands and pending result
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      qsig_q  <= in_sig;
      qfuse_q <= in_fuse;
      res_q   <= '0;
    end else if (cmd_i.scan && done) begin
      res_q <= res_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_data_q <= res_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_data_q;
  assign sts_o.is_query = (in_user_i == dsfc_pkg::FUNC_QUERY);
  assign sts_o.no_dev   = (in_sig == dsfc_pkg::SIG_ERASED);
  assign sts_o.done     = done;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

endmodule

// ===== rtl/device_signature_fuse_check.sv =====
// channel   dir  tdata (low bit up)                                     tuser
// s_axis    in   index 6, signature 24, fuse_low 8, fuse_ext 8,        func
//                fuse_lock 8, mask_low 8, mask_ext 8, mask_lock 8, pad 2
// m_axis    out  red_on 1, green_on 1, hit_index 6                     -
//
// a load item is taken in idle, leaves the input open and produces no transfer on m_axis
// a query walks the record store from slot 0, one slot per cycle through the single
// read port, up to an erased slot, a match or the last slot; the input stays closed
// until its result enters the output register, and a no-device query skips the scan
// after reset the store reads as erased, as reset clears every valid bit
// a stalled result sits in the output register while the next item runs
module device_signature_fuse_check (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // index, signature, fuse_low, fuse_ext, fuse_lock, mask_low, mask_ext, mask_lock
  input  logic [dsfc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // func
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // red_on, green_on, hit_index
  output logic [dsfc_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  dsfc_pkg::cmd_t cmd;
  dsfc_pkg::sts_t sts;

  dsfc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dsfc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

`ifndef SYNTH
  // a query closes the input in the cycle after it is taken
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == dsfc_pkg::FUNC_QUERY)
    |=> !s_axis_tready)
    else $error("input open right after a query");

  // a load completes in its own cycle
  a_load_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == dsfc_pkg::FUNC_LOAD)
    |=> s_axis_tready)
    else $error("input closed after a load");

  // a result without green carries slot zero
  a_miss_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[1] |-> (m_axis_tdata[7:2] == '0))
    else $error("miss with nonzero slot");

  // a result is loaded only into a free output register
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result overwrites a pending transfer");
`endif

endmodule

// ===== verif/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT  = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int RAND_ITEMS  = 1500;
  localparam int MAX_PRINTS  = 50;

  // one input item: fuse and mask bytes are low 23..16, ext 15..8, lock 7..0
  typedef struct packed {
    logic                        func;
    logic [dsfc_pkg::IDX_W-1:0]  index;
    logic [dsfc_pkg::SIG_W-1:0]  sig;
    logic [dsfc_pkg::FUSE_W-1:0] fuse;
    logic [dsfc_pkg::FUSE_W-1:0] mask;
  } chk_item_t;

  typedef struct packed {
    logic                       red;
    logic                       green;
    logic [dsfc_pkg::IDX_W-1:0] slot;
  } verdict_t;

  logic                            clk_i;
  logic                            rst_ni = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [dsfc_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                            s_axis_tuser = dsfc_pkg::FUNC_LOAD;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [dsfc_pkg::OUT_DATA_W-1:0] m_axis_tdata;

  device_signature_fuse_check u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // stimulus and expectations
  chk_item_t pending_items[$];
  verdict_t  verdict_q[$];
  chk_item_t cur_item;

  // record store as the block should see it
  dsfc_pkg::rec_t record_db [dsfc_pkg::RECORDS];

  // what the generator has loaded so far, used to aim queries
  logic [dsfc_pkg::SIG_W-1:0]  gen_sig  [dsfc_pkg::RECORDS];
  logic [dsfc_pkg::FUSE_W-1:0] gen_fuse [dsfc_pkg::RECORDS];
  logic [dsfc_pkg::FUSE_W-1:0] gen_mask [dsfc_pkg::RECORDS];

  int accepted_items = 0;
  int mismatches     = 0;
  int n_loads = 0, n_queries = 0, n_clean = 0, n_dirty = 0, n_miss = 0, n_nodev = 0;
  int burst_left = 1;
  int gap_left   = 0;
  int rdy_mode   = 0;
  int rdy_left   = 0;
  int idle_cycles = 0;
  logic hold_off = 1'b0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic void add_load(input logic [dsfc_pkg::IDX_W-1:0]  idx,
                                   input logic [dsfc_pkg::SIG_W-1:0]  sig,
                                   input logic [dsfc_pkg::FUSE_W-1:0] fuse,
                                   input logic [dsfc_pkg::FUSE_W-1:0] mask);
    chk_item_t it;
    it.func  = dsfc_pkg::FUNC_LOAD;
    it.index = idx;
    it.sig   = sig;
    it.fuse  = fuse;
    it.mask  = mask;
    pending_items.push_back(it);
    gen_sig[idx]  = sig;
    gen_fuse[idx] = fuse;
    gen_mask[idx] = mask;
  endfunction

  // index and masks are don't-care for a query, so they carry noise
  function automatic void add_query(input logic [dsfc_pkg::SIG_W-1:0]  sig,
                                    input logic [dsfc_pkg::FUSE_W-1:0] fuse);
    chk_item_t it;
    it.func  = dsfc_pkg::FUNC_QUERY;
    it.index = dsfc_pkg::IDX_W'($urandom_range(0, dsfc_pkg::RECORDS - 1));
    it.sig   = sig;
    it.fuse  = fuse;
    it.mask  = dsfc_pkg::FUSE_W'($urandom_range(0, 24'hFFFFFF));
    pending_items.push_back(it);
  endfunction

  // expected outcome of one accepted item, updates the record store on loads
  function automatic void predict_verdict(input chk_item_t it);
    verdict_t v;
    bit       hit;
    int       slot;
    if (it.func == dsfc_pkg::FUNC_LOAD) begin
      record_db[it.index] = '{sig: it.sig, fuse: it.fuse, mask: it.mask};
      n_loads++;
      return;
    end
    n_queries++;
    v = '0;
    if (it.sig == dsfc_pkg::SIG_ERASED) begin
      n_nodev++;
      verdict_q.push_back(v);
      return;
    end
    hit  = 1'b0;
    slot = 0;
    // scan from slot 0, stop at the first erased signature or first match
    for (int k = 0; k < dsfc_pkg::RECORDS; k++) begin
      if (record_db[k].sig == dsfc_pkg::SIG_ERASED) break;
      if (record_db[k].sig == it.sig) begin
        hit  = 1'b1;
        slot = k;
        break;
      end
    end
    if (!hit) begin
      v.red = 1'b1;
      n_miss++;
    end else begin
      v.green = 1'b1;
      v.slot  = slot[dsfc_pkg::IDX_W-1:0];
      v.red   = |((it.fuse ^ record_db[slot].fuse) & record_db[slot].mask);
      if (v.red) n_dirty++;
      else n_clean++;
    end
    verdict_q.push_back(v);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    // keep the log short when the block is badly off
    if (mismatches < MAX_PRINTS)
      $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // driver: bursts of transfers with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= dsfc_pkg::FUNC_LOAD;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_verdict(cur_item);
        accepted_items++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          gap_left      <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          cur_item      = pending_items.pop_front();
          s_axis_tdata  <= {2'b00, cur_item.mask[7:0], cur_item.mask[15:8], cur_item.mask[23:16],
                            cur_item.fuse[7:0], cur_item.fuse[15:8], cur_item.fuse[23:16],
                            cur_item.sig, cur_item.index};
          s_axis_tuser  <= cur_item.func;
          s_axis_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern switches between always ready, coin flip and mostly stalled
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (rdy_left == 0) begin
        rdy_mode <= $urandom_range(0, 2);
        rdy_left <= $urandom_range(5, 60);
      end else begin
        rdy_left <= rdy_left - 1;
      end
      case (rdy_mode)
        0:       m_axis_tready <= !hold_off;
        1:       m_axis_tready <= !hold_off && ($urandom_range(0, 1) == 1);
        default: m_axis_tready <= !hold_off && ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // long receiver hold-off once traffic is flowing, so the input backs up
  initial begin
    while (accepted_items < 200) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // monitor: compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (verdict_q.size() == 0) begin
        report_mismatch("unexpected result transfer", int'(m_axis_tdata), -1);
      end else begin
        want = verdict_q.pop_front();
        if (m_axis_tdata[0] !== want.red)
          report_mismatch("red_on", int'(m_axis_tdata[0]), int'(want.red));
        if (m_axis_tdata[1] !== want.green)
          report_mismatch("green_on", int'(m_axis_tdata[1]), int'(want.green));
        if (m_axis_tdata[7:2] !== want.slot)
          report_mismatch("hit_index", int'(m_axis_tdata[7:2]), int'(want.slot));
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("testbench NOT OK");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    int                          total;
    int                          n_fill;
    int                          n_q;
    int                          pick;
    int                          k;
    logic [dsfc_pkg::SIG_W-1:0]  sig_pool [16];
    logic [dsfc_pkg::SIG_W-1:0]  sig;
    logic [dsfc_pkg::FUSE_W-1:0] fuse;
    logic [dsfc_pkg::FUSE_W-1:0] mask;

    for (int i = 0; i < dsfc_pkg::RECORDS; i++) begin
      record_db[i] = '1;
      gen_sig[i]   = '1;
      gen_fuse[i]  = '1;
      gen_mask[i]  = '1;
    end
    for (int i = 0; i < 16; i++) sig_pool[i] = dsfc_pkg::SIG_W'($urandom_range(0, 24'hFFFFFE));

    // directed: empty table, no device, clean and dirty matches, masking,
    // end of table, record beyond a gap, erasing a record, duplicates
    add_query(dsfc_pkg::SIG_ERASED, 24'h000000);
    add_query(24'h000000, 24'hFFFFFF);
    add_load(6'd0, 24'h000000, 24'h000000, 24'hFFFFFF);
    add_query(24'h000000, 24'h000000);
    add_load(6'd1, 24'h1E9502, 24'hFFFFFF, 24'hFFFFFF);
    add_query(24'h1E9502, 24'hFFFFFF);
    add_query(24'h1E9502, 24'h7FFFFF);
    add_query(24'h1E9502, 24'hFFFEFF);
    add_query(24'h1E9502, 24'hFFFF00);
    add_load(6'd2, 24'hABCDEF, 24'h5AA53C, 24'h0FF000);
    add_query(24'hABCDEF, 24'hAAA5FF);
    add_query(24'hABCDEF, 24'h5BA53C);
    add_query(24'hFFFFFE, 24'h000000);
    add_load(6'd63, 24'h123456, 24'h000000, 24'h000000);
    add_query(24'h123456, 24'hFFFFFF);
    add_load(6'd3, 24'h7F8001, 24'h123456, 24'h000000);
    add_query(24'h7F8001, 24'hEDCBA9);
    add_load(6'd1, dsfc_pkg::SIG_ERASED, 24'hFFFFFF, 24'hFFFFFF);
    add_query(24'hABCDEF, 24'h5AA53C);
    add_load(6'd1, 24'h000000, 24'hFFFFFF, 24'hFFFFFF);
    add_query(24'h000000, 24'hFFFFFF);
    add_query(dsfc_pkg::SIG_ERASED, 24'hFFFFFF);

    // random: fill a run of slots, then mostly aimed queries with some noise
    total = pending_items.size() + RAND_ITEMS;
    for (int round = 0; pending_items.size() < total; round++) begin
      n_fill = (round == 0 || $urandom_range(0, 3) == 0) ? dsfc_pkg::RECORDS
                                                         : $urandom_range(1, 16);
      for (int s = 0; s < n_fill; s++) begin
        sig = ($urandom_range(0, 3) == 0) ? sig_pool[$urandom_range(0, 15)]
                                          : dsfc_pkg::SIG_W'($urandom_range(0, 24'hFFFFFE));
        case ($urandom_range(0, 2))
          0:       mask = 24'hFFFFFF;
          1:       mask = 24'h000000;
          default: mask = dsfc_pkg::FUSE_W'($urandom_range(0, 24'hFFFFFF));
        endcase
        fuse = dsfc_pkg::FUSE_W'($urandom_range(0, 24'hFFFFFF));
        add_load(s[dsfc_pkg::IDX_W-1:0], sig, fuse, mask);
      end
      n_q = $urandom_range(4, 24);
      for (int q = 0; q < n_q; q++) begin
        pick = $urandom_range(0, 99);
        k    = $urandom_range(0, n_fill - 1);
        if (pick < 70) begin
          case ($urandom_range(0, 2))
            0:       fuse = gen_fuse[k];
            1:       fuse = gen_fuse[k] ^
                            (dsfc_pkg::FUSE_W'($urandom_range(0, 24'hFFFFFF)) & ~gen_mask[k]);
            default: fuse = gen_fuse[k] ^ dsfc_pkg::FUSE_W'($urandom_range(0, 24'hFFFFFF));
          endcase
          add_query(gen_sig[k], fuse);
        end else if (pick < 80) begin
          sig  = dsfc_pkg::SIG_W'($urandom_range(0, 24'hFFFFFF));
          fuse = dsfc_pkg::FUSE_W'($urandom_range(0, 24'hFFFFFF));
          add_query(sig, fuse);
        end else if (pick < 85) begin
          add_query(dsfc_pkg::SIG_ERASED, dsfc_pkg::FUSE_W'($urandom_range(0, 24'hFFFFFF)));
        end else if (pick < 93) begin
          sig  = ($urandom_range(0, 4) == 0) ? dsfc_pkg::SIG_ERASED
                                             : dsfc_pkg::SIG_W'($urandom_range(0, 24'hFFFFFF));
          fuse = dsfc_pkg::FUSE_W'($urandom_range(0, 24'hFFFFFF));
          mask = dsfc_pkg::FUSE_W'($urandom_range(0, 24'hFFFFFF));
          add_load(dsfc_pkg::IDX_W'($urandom_range(0, dsfc_pkg::RECORDS - 1)), sig, fuse, mask);
        end else begin
          // erase a record in the middle, cutting the scan short
          fuse = dsfc_pkg::FUSE_W'($urandom_range(0, 24'hFFFFFF));
          mask = dsfc_pkg::FUSE_W'($urandom_range(0, 24'hFFFFFF));
          add_load(k[dsfc_pkg::IDX_W-1:0], dsfc_pkg::SIG_ERASED, fuse, mask);
        end
      end
    end
    total = pending_items.size();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_items < total) @(posedge clk_i);
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (dsfc_pkg::RECORDS + 8) @(posedge clk_i);

    $display("covered %0d loads and %0d queries: %0d clean hits, %0d fuse mismatches,",
             n_loads, n_queries, n_clean, n_dirty);
    $display("%0d misses, %0d with no device; %0d mismatches seen", n_miss, n_nodev, mismatches);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ===== device_signature_fuse_check.f =====
rtl/dsfc_pkg.sv
rtl/dsfc_ctrl.sv
rtl/dsfc_dp.sv
rtl/device_signature_fuse_check.sv
verif/testbench.sv
